>>> rtl/hkrb_pkg.sv
package hkrb_pkg;

    localparam int TABLE_DEPTH  = 32;
    localparam int KEY_SLOTS    = 6;
    localparam int BITMAP_BYTES = 4;

    localparam int BITMAP_BITS  = 8 * BITMAP_BYTES;
    localparam int TBL_AW       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int BIT_W        = $clog2(BITMAP_BITS);
    localparam int REPORT_SLOTS = 6;
    localparam int REPORT_BITS  = 32;
    localparam int CFG_IDX_W    = 2;

    localparam logic [7:0] ROLLOVER_CODE = 8'd1;
    localparam logic [5:0] TABLE_ENTRIES_RST = 6'd21;
    localparam logic [7:0] END_OF_SCAN_RST   = 8'd255;

    localparam logic [1:0] OP_KEY      = 2'd0;
    localparam logic [1:0] OP_LOAD     = 2'd1;
    localparam logic [1:0] OP_CLEAR    = 2'd2;
    localparam logic [1:0] OP_ROLLOVER = 2'd3;

    localparam logic [1:0] TYPE_NONE = 2'd0;
    localparam logic [1:0] TYPE_STD  = 2'd1;
    localparam logic [1:0] TYPE_MOD  = 2'd2;
    localparam logic [1:0] TYPE_BIT  = 2'd3;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_STD    = 2'd1;
    localparam logic [1:0] KIND_BIT    = 2'd2;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_TABLE_ENTRIES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_OF_SCAN   = 2'd1;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] key_index;
        logic       key_down;
        logic [2:0] entry_type;
        logic [7:0] entry_code;
        logic       send_after_clear;
    } hkrb_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        status;
        logic [7:0]  modifiers;
        logic [7:0]  slot_0;
        logic [7:0]  slot_1;
        logic [7:0]  slot_2;
        logic [7:0]  slot_3;
        logic [7:0]  slot_4;
        logic [7:0]  slot_5;
        logic [31:0] bitmap_bits;
        logic        last;
    } hkrb_out_t;

    typedef struct packed {
        logic [1:0] etype;
        logic [7:0] code;
    } hkrb_entry_t;

    typedef struct packed {
        logic       clear;
        logic       apply;
        logic       down;
        logic [7:0] code;
    } hkrb_slot_cmd_t;

    typedef struct packed {
        logic hit;
        logic empty;
    } hkrb_link_t;

endpackage

>>> rtl/hkrb_slot_cell.sv
module hkrb_slot_cell
    import hkrb_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  hkrb_slot_cmd_t cmd,
    input  hkrb_link_t     link_in,
    input  logic [7:0]     right_slot,
    output hkrb_link_t     link_out,
    output logic [7:0]     slot
);

    logic [7:0] slot_reg;
    logic [7:0] slot_next;
    logic       match;
    logic       is_empty;

    assign is_empty = (slot_reg == 8'd0);
    assign match    = !is_empty && (slot_reg == cmd.code);

    assign link_out.hit   = link_in.hit | match;
    assign link_out.empty = link_in.empty | is_empty;
    assign slot           = slot_reg;

    always_comb
    begin
        slot_next = slot_reg;
        if (cmd.clear)
        begin
            slot_next = 8'd0;
        end
        else if (cmd.apply)
        begin
            if (cmd.down)
            begin
                // first free slot takes the code unless it is already held
                if (is_empty && !link_in.empty && !link_in.hit)
                begin
                    slot_next = cmd.code;
                end
            end
            else if (link_in.hit || match)
            begin
                slot_next = right_slot;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= 8'd0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

endmodule

>>> rtl/hkrb_xlat_table.sv
module hkrb_xlat_table
    import hkrb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [TBL_AW-1:0] wr_addr,
    input  hkrb_entry_t       wr_entry,
    input  logic [TBL_AW-1:0] rd_addr,
    output hkrb_entry_t       rd_entry
);

    hkrb_entry_t                mem_reg [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]     valid_reg;
    hkrb_entry_t                rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_entry;
        end
        // entries never loaded read as type none
        if (valid_reg[rd_addr])
        begin
            rd_reg <= mem_reg[rd_addr];
        end
        else
        begin
            rd_reg <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_entry = rd_reg;

endmodule

>>> rtl/hid_key_report_builder_top.sv
// keyboard report builder, six-key rollover with modifier byte and bitmapped report
// input channel in_valid/in_ready/in_item: key events, table loads, clear and rollover ops
// output channel out_valid/out_ready/out_item: one or two result items per input item,
//   standard report before bitmapped report, last marks the final item of an input
// config channel cfg_valid/cfg_ready/cfg_index/cfg_data, always ready, write only while idle
// an input item is taken in S_IDLE, the table entry is read in S_READ (registered
// translation table read), the update is applied through the slot cell chain in S_EXEC
// and the results are loaded into the output register in S_EMIT
// one input item occupies the block until its last result is loaded, so the block takes
// no new item before it is through with the last one
// in_ready returns high as soon as the last result is in the output register, so the next
// item is taken while that result still waits for out_ready
// a stalled receiver holds the output register and the sequencer waits, no result is lost
// reset clears slots, modifier byte, bitmap and table valid bits, sets table_entries to 21
// and end_of_scan_code to 255; no clearing pass is needed
module hid_key_report_builder_top
    import hkrb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  hkrb_in_t             in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output hkrb_out_t            out_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_EXEC = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    typedef enum logic [1:0] {
        RES_STATUS = 2'd0,
        RES_STD    = 2'd1,
        RES_BIT    = 2'd2,
        RES_ROLL   = 2'd3
    } res_t;

    state_t                 state_reg, state_next;
    hkrb_in_t               item_reg;
    logic [5:0]             te_reg;
    logic [7:0]             eos_reg;
    logic [7:0]             mod_reg, mod_next;
    logic [BITMAP_BITS-1:0] bitmap_reg, bitmap_next;
    res_t                   res0_reg, res0_next;
    res_t                   res1_reg, res1_next;
    logic                   two_reg, two_next;
    logic                   ptr_reg, ptr_next;
    logic                   status_reg, status_next;
    logic                   out_valid_reg, out_valid_next;
    hkrb_out_t              out_item_reg, out_item_next;

    hkrb_entry_t            tbl_rd;
    hkrb_entry_t            tbl_wr;
    logic                   tbl_we;

    hkrb_slot_cmd_t         slot_cmd;
    hkrb_link_t             link [KEY_SLOTS+1];
    logic [7:0]             slot_q [KEY_SLOTS];
    logic [7:0]             std_pad [REPORT_SLOTS];
    logic [7:0]             roll_pad [REPORT_SLOTS];
    logic [REPORT_BITS-1:0] bitmap_out;

    logic                   idx_ok;
    logic                   load_ok;
    logic                   bit_hit;
    logic [7:0]             mod_new;
    logic                   std_chg;
    logic                   bit_chg;
    logic                   slot_chg;
    logic                   load_out;
    logic                   last_res;
    res_t                   cur_res;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // translation table
    assign tbl_wr.etype = item_reg.entry_type[1:0];
    assign tbl_wr.code  = item_reg.entry_code;

    hkrb_xlat_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (tbl_we),
        .wr_addr  (item_reg.key_index[TBL_AW-1:0]),
        .wr_entry (tbl_wr),
        .rd_addr  (item_reg.key_index[TBL_AW-1:0]),
        .rd_entry (tbl_rd)
    );

    // key slot chain
    assign idx_ok  = ({1'b0, item_reg.key_index} < {3'b000, te_reg})
                  && ({1'b0, item_reg.key_index} < 9'(TABLE_DEPTH));
    assign load_ok = ({1'b0, item_reg.key_index} < 9'(TABLE_DEPTH));

    assign slot_cmd.clear = (state_reg == S_EXEC) && (item_reg.op == OP_CLEAR);
    assign slot_cmd.apply = (state_reg == S_EXEC) && (item_reg.op == OP_KEY) && idx_ok
                         && (tbl_rd.etype == TYPE_STD);
    assign slot_cmd.down  = item_reg.key_down;
    assign slot_cmd.code  = tbl_rd.code;

    assign link[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < KEY_SLOTS; gi++)
        begin : g_cell
            logic [7:0] right;
            if (gi < KEY_SLOTS - 1)
            begin : g_mid
                assign right = slot_q[gi+1];
            end
            else
            begin : g_end
                assign right = 8'd0;
            end

            hkrb_slot_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (slot_cmd),
                .link_in    (link[gi]),
                .right_slot (right),
                .link_out   (link[gi+1]),
                .slot       (slot_q[gi])
            );
        end

        for (gi = 0; gi < REPORT_SLOTS; gi++)
        begin : g_pad
            if (gi < KEY_SLOTS)
            begin : g_used
                assign std_pad[gi]  = slot_q[gi];
                assign roll_pad[gi] = ROLLOVER_CODE;
            end
            else
            begin : g_unused
                assign std_pad[gi]  = 8'd0;
                assign roll_pad[gi] = 8'd0;
            end
        end

        for (gi = 0; gi < REPORT_BITS; gi++)
        begin : g_bits
            if (gi < BITMAP_BITS)
            begin : g_used
                assign bitmap_out[gi] = bitmap_reg[gi];
            end
            else
            begin : g_unused
                assign bitmap_out[gi] = 1'b0;
            end
        end
    endgenerate

    assign slot_chg = slot_cmd.down ? (link[KEY_SLOTS].empty && !link[KEY_SLOTS].hit)
                                    : link[KEY_SLOTS].hit;
    assign mod_new  = item_reg.key_down ? (mod_reg | tbl_rd.code)
                                        : (mod_reg & ~tbl_rd.code);
    assign bit_hit  = ({1'b0, tbl_rd.code} < 9'(BITMAP_BITS));

    // item execution
    always_comb
    begin
        res0_next   = res0_reg;
        res1_next   = res1_reg;
        two_next    = two_reg;
        status_next = status_reg;
        mod_next    = mod_reg;
        bitmap_next = bitmap_reg;
        tbl_we      = 1'b0;
        std_chg     = 1'b0;
        bit_chg     = 1'b0;
        if (state_reg == S_EXEC)
        begin
            res0_next   = RES_STATUS;
            res1_next   = RES_STATUS;
            two_next    = 1'b0;
            status_next = STATUS_OK;
            unique case (item_reg.op)
                OP_KEY:
                begin
                    if (idx_ok)
                    begin
                        case (tbl_rd.etype)
                            TYPE_STD:
                            begin
                                std_chg = slot_chg;
                            end
                            TYPE_MOD:
                            begin
                                mod_next = mod_new;
                                std_chg  = (mod_new != mod_reg);
                            end
                            TYPE_BIT:
                            begin
                                if (bit_hit)
                                begin
                                    bitmap_next[tbl_rd.code[BIT_W-1:0]] = item_reg.key_down;
                                end
                                bit_chg = 1'b1;
                            end
                            default:
                            begin
                            end
                        endcase
                        if (std_chg)
                        begin
                            res0_next = RES_STD;
                        end
                        else if (bit_chg)
                        begin
                            res0_next = RES_BIT;
                        end
                    end
                    else if (item_reg.key_index != eos_reg)
                    begin
                        status_next = STATUS_BAD;
                    end
                end
                OP_LOAD:
                begin
                    if (!load_ok)
                    begin
                        status_next = STATUS_BAD;
                    end
                    else if (!item_reg.entry_type[2])
                    begin
                        tbl_we = 1'b1;
                    end
                end
                OP_CLEAR:
                begin
                    mod_next    = 8'd0;
                    bitmap_next = '0;
                    if (item_reg.send_after_clear)
                    begin
                        res0_next = RES_STD;
                        res1_next = RES_BIT;
                        two_next  = 1'b1;
                    end
                end
                OP_ROLLOVER:
                begin
                    res0_next = RES_ROLL;
                end
                default:
                begin
                end
            endcase
        end
    end

    // result assembly
    assign cur_res  = ptr_reg ? res1_reg : res0_reg;
    assign last_res = !two_reg || ptr_reg;
    assign load_out = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_item_next      = '0;
        out_item_next.last = last_res;
        case (cur_res)
            RES_STATUS:
            begin
                out_item_next.kind   = KIND_STATUS;
                out_item_next.status = status_reg;
            end
            RES_STD:
            begin
                out_item_next.kind      = KIND_STD;
                out_item_next.modifiers = mod_reg;
                out_item_next.slot_0    = std_pad[0];
                out_item_next.slot_1    = std_pad[1];
                out_item_next.slot_2    = std_pad[2];
                out_item_next.slot_3    = std_pad[3];
                out_item_next.slot_4    = std_pad[4];
                out_item_next.slot_5    = std_pad[5];
            end
            RES_BIT:
            begin
                out_item_next.kind        = KIND_BIT;
                out_item_next.bitmap_bits = bitmap_out;
            end
            RES_ROLL:
            begin
                out_item_next.kind   = KIND_STD;
                out_item_next.slot_0 = roll_pad[0];
                out_item_next.slot_1 = roll_pad[1];
                out_item_next.slot_2 = roll_pad[2];
                out_item_next.slot_3 = roll_pad[3];
                out_item_next.slot_4 = roll_pad[4];
                out_item_next.slot_5 = roll_pad[5];
            end
            default:
            begin
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                ptr_next   = 1'b0;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    if (last_res)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ptr_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            ptr_reg       <= 1'b0;
            two_reg       <= 1'b0;
            te_reg        <= TABLE_ENTRIES_RST;
            eos_reg       <= END_OF_SCAN_RST;
            mod_reg       <= 8'd0;
            bitmap_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            ptr_reg       <= ptr_next;
            two_reg       <= two_next;
            mod_reg       <= mod_next;
            bitmap_reg    <= bitmap_next;
            if (cfg_valid)
            begin
                if (cfg_index == REG_TABLE_ENTRIES)
                begin
                    te_reg <= cfg_data[5:0];
                end
                else if (cfg_index == REG_END_OF_SCAN)
                begin
                    eos_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
        res0_reg   <= res0_next;
        res1_reg   <= res1_next;
        status_reg <= status_next;
        if (load_out)
        begin
            out_item_reg <= out_item_next;
        end
    end

endmodule

>>> rtl/hkrb_checker.sv
module hkrb_checker
    import hkrb_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input hkrb_out_t out_item
);

    // one item at a time: the input closes after each accepted item
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted on consecutive cycles");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("stalled result item changed");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.kind == KIND_STATUS || out_item.kind == KIND_STD
                    || out_item.kind == KIND_BIT))
        else $error("illegal result kind");

    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.kind == KIND_STATUS |->
            out_item.modifiers == 8'd0 && out_item.bitmap_bits == 32'd0
            && out_item.slot_0 == 8'd0 && out_item.slot_5 == 8'd0)
        else $error("status item carries report data");

    a_report_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.kind != KIND_STATUS |-> out_item.status == STATUS_OK)
        else $error("report item carries error status");

endmodule

bind hid_key_report_builder_top hkrb_checker u_hkrb_checker (.*);
